>>> src/rsct_pkg.sv
// Shared constants and types of the running statistics counter table.
`default_nettype none
package rsct_pkg;

	localparam int NUM_COUNTERS = 64;
	localparam int SAMPLE_BITS  = 24;
	localparam int CNT_AW       = $clog2(NUM_COUNTERS);

	localparam int IDX_W   = 6;
	localparam int AMT_W   = 24;
	localparam int TOTAL_W = 48;
	localparam int COUNT_W = 32;
	localparam int MEAN_W  = 40;
	localparam int SQ_W    = 64;
	localparam int FRAC_W  = 16;
	localparam int PROD_W  = 2 * MEAN_W;
	localparam int DIGIT_W = 8;
	localparam int MUL_STEPS = MEAN_W / DIGIT_W;
	localparam int SQ_SHIFT  = 24;

	localparam logic [AMT_W-1:0] SAMPLE_MASK = AMT_W'((64'd1 << SAMPLE_BITS) - 64'd1);

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [COUNT_W-1:0] sample_count;
		logic [AMT_W-1:0]   minimum;
		logic [AMT_W-1:0]   maximum;
		logic [MEAN_W-1:0]  mean;
		logic [SQ_W-1:0]    sq_dev_sum;
		logic               overflow;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

>>> src/rsct_req_if.sv
// Request channel: one add or clear request for one counter.
`default_nettype none
interface rsct_req_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [rsct_pkg::IDX_W-1:0]    counter_index;
	logic [rsct_pkg::AMT_W-1:0]    amount;

	modport source(output valid, output action, output counter_index, output amount,
		input ready);
	modport sink(input valid, input action, input counter_index, input amount,
		output ready);
endinterface
`default_nettype wire

>>> src/rsct_rsp_if.sv
// Response channel: updated figures of one counter.
`default_nettype none
interface rsct_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rsct_pkg::TOTAL_W-1:0]  total;
	logic [rsct_pkg::COUNT_W-1:0]  sample_count;
	logic [rsct_pkg::AMT_W-1:0]    minimum;
	logic [rsct_pkg::AMT_W-1:0]    maximum;
	logic [rsct_pkg::MEAN_W-1:0]   mean;
	logic [rsct_pkg::SQ_W-1:0]     sq_dev_sum;
	logic                          overflow;

	modport source(output valid, output total, output sample_count, output minimum,
		output maximum, output mean, output sq_dev_sum, output overflow, input ready);
	modport sink(input valid, input total, input sample_count, input minimum,
		input maximum, input mean, input sq_dev_sum, input overflow, output ready);
endinterface
`default_nettype wire

>>> src/rsct_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/running_statistics_counter_table_core.sv
// Sequence: a clear returns its response in the cycle after acceptance; a first sample passes
// through read and write back. Any later sample runs read, 40 divider steps, mean update,
// 5 multiply digit steps, squared-sum add, write back; write back waits for a free response slot.
// Throughput: one request at a time; the 40-step restoring divider dominates a later sample.
// Reset (arst_n low): all counters read as cleared at once through per-entry valid bits;
// no clearing pass, requests are taken right after reset.
`default_nettype none
module running_statistics_counter_table_core (
	input  logic          clk,
	input  logic          arst_n,
	rsct_req_if.sink      req,
	rsct_rsp_if.source    rsp
);
	import rsct_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_MEAN = 3'd3;
	localparam logic [2:0] ST_MUL  = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;
	localparam logic [2:0] ST_WR   = 3'd6;

	localparam logic [5:0] DIV_LAST = 6'(MEAN_W - 1);
	localparam logic [5:0] MUL_LAST = 6'(MUL_STEPS - 1);

	// Sequencer and table bookkeeping
	logic [2:0]              state_q;
	logic [NUM_COUNTERS-1:0] valid_q;
	logic [CNT_AW-1:0]       addr_q;
	logic [AMT_W-1:0]        x_q;
	entry_t                  ent_q;
	logic                    neg_q;
	logic [MEAN_W-1:0]       mag1_q;
	logic [5:0]              step_q;

	// Shared divider and multiplier registers
	logic [COUNT_W-1:0]      rem_q;
	logic [MEAN_W-1:0]       dq_q;
	logic [MEAN_W-1:0]       mulb_q;
	logic [PROD_W-1:0]       acc_q;

	// Response register
	logic                    rsp_v_q;
	entry_t                  rsp_d_q;

	logic                    rsp_free;
	logic                    rsp_set;
	logic                    accept;
	logic                    in_range;
	logic                    wr_go;
	logic [ENTRY_W-1:0]      ram_rdata;
	entry_t                  old_e;
	logic                    old_valid;
	logic [MEAN_W-1:0]       xq;
	logic [TOTAL_W:0]        tsum;
	logic [COUNT_W:0]        rem_sh;
	logic                    q_bit;
	logic [MEAN_W-1:0]       m_new;
	logic [MEAN_W-1:0]       mag2;
	logic [MEAN_W+DIGIT_W-1:0] pp;
	logic [SQ_W:0]           sq_sum;

	assign rsp_free  = !rsp_v_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && rsp_free;
	assign accept    = req.valid && req.ready;
	assign in_range  = 32'(req.counter_index) < NUM_COUNTERS;
	assign wr_go     = (state_q == ST_WR) && rsp_free;
	// Post a response on a clear, an out-of-table request or a write back
	assign rsp_set   = (accept && (req.action || !in_range)) || wr_go;

	rsct_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_COUNTERS)
	) u_table (
		.clk   (clk),
		.we    (wr_go),
		.waddr (addr_q),
		.wdata (ent_q),
		.raddr (CNT_AW'(req.counter_index)),
		.rdata (ram_rdata)
	);

	// An entry that is not valid reads as a cleared counter
	assign old_valid = valid_q[addr_q];
	assign old_e     = entry_t'(ram_rdata);
	assign xq        = {x_q, {FRAC_W{1'b0}}};
	assign tsum      = (old_valid ? {1'b0, old_e.total} : '0) + (TOTAL_W + 1)'(x_q);

	// Restoring division step: one quotient bit per cycle, dividend shifts in from dq_q
	assign rem_sh = {rem_q, dq_q[MEAN_W-1]};
	assign q_bit  = rem_sh >= {1'b0, ent_q.sample_count};

	// Mean moves by the truncated quotient toward the sample
	assign m_new = neg_q ? (ent_q.mean - dq_q) : (ent_q.mean + dq_q);
	assign mag2  = neg_q ? (m_new - xq) : (xq - m_new);

	// One 40x8 partial product per cycle, most significant digit first
	assign pp     = (MEAN_W + DIGIT_W)'(mag1_q)
		* (MEAN_W + DIGIT_W)'(mulb_q[MEAN_W-1 -: DIGIT_W]);
	assign sq_sum = {1'b0, ent_q.sq_dev_sum} + (SQ_W + 1)'(acc_q[PROD_W-1:SQ_SHIFT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_v_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.action || !in_range) begin
							// clear or out-of-table request answers with zeros
							if (in_range) begin
								valid_q[CNT_AW'(req.counter_index)] <= 1'b0;
							end
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= old_valid ? ST_DIV : ST_WR;
				end
				ST_DIV: begin
					if (step_q == DIV_LAST) begin
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == MUL_LAST) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (rsp_free) begin
						valid_q[addr_q] <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: payload registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q <= CNT_AW'(req.counter_index);
				x_q    <= req.amount & SAMPLE_MASK;
				if (accept && (req.action || !in_range)) begin
					rsp_d_q <= '0;
				end
			end
			ST_RD: begin
				ent_q.total    <= tsum[TOTAL_W] ? '1 : tsum[TOTAL_W-1:0];
				step_q         <= '0;
				rem_q          <= '0;
				if (!old_valid) begin
					// first sample seeds the figures
					ent_q.sample_count <= COUNT_W'(1);
					ent_q.minimum      <= x_q;
					ent_q.maximum      <= x_q;
					ent_q.mean         <= xq;
					ent_q.sq_dev_sum   <= '0;
					ent_q.overflow     <= tsum[TOTAL_W];
				end else begin
					ent_q.sample_count <= (&old_e.sample_count) ? old_e.sample_count
						: old_e.sample_count + COUNT_W'(1);
					ent_q.minimum      <= (x_q < old_e.minimum) ? x_q : old_e.minimum;
					ent_q.maximum      <= (x_q > old_e.maximum) ? x_q : old_e.maximum;
					ent_q.mean         <= old_e.mean;
					ent_q.sq_dev_sum   <= old_e.sq_dev_sum;
					ent_q.overflow     <= old_e.overflow | tsum[TOTAL_W]
						| (&old_e.sample_count);
					neg_q              <= xq < old_e.mean;
					mag1_q             <= (xq < old_e.mean) ? (old_e.mean - xq)
						: (xq - old_e.mean);
					dq_q               <= (xq < old_e.mean) ? (old_e.mean - xq)
						: (xq - old_e.mean);
				end
			end
			ST_DIV: begin
				rem_q  <= q_bit ? COUNT_W'(rem_sh - {1'b0, ent_q.sample_count})
					: rem_sh[COUNT_W-1:0];
				dq_q   <= {dq_q[MEAN_W-2:0], q_bit};
				step_q <= step_q + 6'd1;
			end
			ST_MEAN: begin
				ent_q.mean <= m_new;
				mulb_q     <= mag2;
				acc_q      <= '0;
				step_q     <= '0;
			end
			ST_MUL: begin
				acc_q  <= {acc_q[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}} + PROD_W'(pp);
				mulb_q <= {mulb_q[MEAN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
				step_q <= step_q + 6'd1;
			end
			ST_ACC: begin
				// shifted product fits in 56 bits, only the sum can saturate
				ent_q.sq_dev_sum <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
				ent_q.overflow   <= ent_q.overflow | sq_sum[SQ_W];
			end
			ST_WR: begin
				if (rsp_free) begin
					rsp_d_q <= ent_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid        = rsp_v_q;
	assign rsp.total        = rsp_d_q.total;
	assign rsp.sample_count = rsp_d_q.sample_count;
	assign rsp.minimum      = rsp_d_q.minimum;
	assign rsp.maximum      = rsp_d_q.maximum;
	assign rsp.mean         = rsp_d_q.mean;
	assign rsp.sq_dev_sum   = rsp_d_q.sq_dev_sum;
	assign rsp.overflow     = rsp_d_q.overflow;

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req.ready)
		else $error("request taken while sequencer busy");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (step_q <= DIV_LAST))
		else $error("divider step count out of range");
	a_wr_responds: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go |=> (rsp_v_q && (state_q == ST_IDLE)))
		else $error("write back did not post a response");
	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (ent_q.sample_count != '0))
		else $error("sample written with zero count");
`endif

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench of the running statistics counter table.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import rsct_pkg::*;

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;
	localparam logic [63:0] SQ_SAT = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [TOTAL_W-1:0] TOTAL_SAT = {TOTAL_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_SAT = {COUNT_W{1'b1}};
	localparam int LIMIT_CYCLES = 2_000_000;
	localparam int DRAIN_CYCLES = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsct_req_if req();
	rsct_rsp_if rsp();

	running_statistics_counter_table_core u_dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor's copy of the counter table.
	logic [TOTAL_W-1:0] tot_q   [NUM_COUNTERS];
	logic [COUNT_W-1:0] cnt_q   [NUM_COUNTERS];
	logic [AMT_W-1:0]   min_q   [NUM_COUNTERS];
	logic [AMT_W-1:0]   max_q   [NUM_COUNTERS];
	logic [MEAN_W-1:0]  mean_q  [NUM_COUNTERS];
	logic [SQ_W-1:0]    sq_q    [NUM_COUNTERS];
	logic               ovf_q   [NUM_COUNTERS];

	entry_t figures_due[$];

	int send_idle_pct = 19;
	int recv_idle_pct = 73;
	bit recv_hold = 1'b0;
	int mismatches = 0;
	int cycles = 0;
	int accepted = 0;
	int responses = 0;
	int ovf_seen = 0;

	// Compute the figures a request produces and advance the predictor state.
	function automatic entry_t update_counter(logic action, logic [IDX_W-1:0] idx,
		logic [AMT_W-1:0] amount);
		entry_t r;
		logic [AMT_W-1:0] x;
		logic [63:0] xq, m_old, m_new, mag1, mag2, inc, s;
		logic [127:0] prod;
		logic [48:0] t;
		logic ov;
		r = '0;
		x = amount & SAMPLE_MASK;
		if (action == ACT_CLEAR) begin
			tot_q[idx] = '0;
			cnt_q[idx] = '0;
			ovf_q[idx] = 1'b0;
			return r;
		end
		ov = ovf_q[idx];
		t = {1'b0, tot_q[idx]} + x;
		if (t[48]) begin
			tot_q[idx] = TOTAL_SAT;
			ov = 1'b1;
		end else
			tot_q[idx] = t[47:0];
		xq = 64'(x) << FRAC_W;
		if (cnt_q[idx] == 0) begin
			cnt_q[idx] = 1;
			min_q[idx] = x;
			max_q[idx] = x;
			mean_q[idx] = xq[MEAN_W-1:0];
			sq_q[idx] = '0;
		end else begin
			if (cnt_q[idx] == COUNT_SAT) ov = 1'b1;
			else cnt_q[idx] = cnt_q[idx] + 1;
			if (x < min_q[idx]) min_q[idx] = x;
			if (x > max_q[idx]) max_q[idx] = x;
			m_old = 64'(mean_q[idx]);
			if (xq >= m_old) begin
				mag1 = xq - m_old;
				m_new = m_old + mag1 / 64'(cnt_q[idx]);
				mag2 = xq - m_new;
			end else begin
				mag1 = m_old - xq;
				m_new = m_old - mag1 / 64'(cnt_q[idx]);
				mag2 = m_new - xq;
			end
			mean_q[idx] = m_new[MEAN_W-1:0];
			prod = 128'(mag1) * 128'(mag2);
			if (prod[127:88] != 0) begin
				inc = SQ_SAT;
				ov = 1'b1;
			end else
				inc = prod[87:24];
			s = sq_q[idx] + inc;
			if (s < inc) begin
				s = SQ_SAT;
				ov = 1'b1;
			end
			sq_q[idx] = s;
		end
		ovf_q[idx] = ov;
		r.total = tot_q[idx];
		r.sample_count = cnt_q[idx];
		r.minimum = min_q[idx];
		r.maximum = max_q[idx];
		r.mean = mean_q[idx];
		r.sq_dev_sum = sq_q[idx];
		r.overflow = ov;
		return r;
	endfunction

	// Drive one request and wait for its acceptance; valid stays up for a back-to-back follower.
	task automatic send_request(logic action, logic [IDX_W-1:0] idx, logic [AMT_W-1:0] amount);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= action;
		req.counter_index <= idx;
		req.amount <= amount;
		do @(posedge clk); while (!req.ready);
		figures_due.push_back(update_counter(action, idx, amount));
		accepted++;
	endtask

	// Drop valid and hold until every expected response has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		do @(posedge clk); while (figures_due.size() != 0);
	endtask

	// Receiver: stall at random, or hold off entirely while recv_hold is set.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Compare each response with the oldest expected figures.
	always @(posedge clk) begin
		entry_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got.total = rsp.total;
			got.sample_count = rsp.sample_count;
			got.minimum = rsp.minimum;
			got.maximum = rsp.maximum;
			got.mean = rsp.mean;
			got.sq_dev_sum = rsp.sq_dev_sum;
			got.overflow = rsp.overflow;
			responses++;
			if (got.overflow) ovf_seen++;
			if (figures_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", got);
			end else begin
				want = figures_due.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at response %0d: expected %p got %p",
							responses, want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	typedef struct {
		logic action;
		logic [IDX_W-1:0] idx;
		logic [AMT_W-1:0] amount;
		bit typed;
		entry_t want;
	} stim_row_t;

	// Build one random request; mostly adds, biased toward a few hot counters.
	task automatic random_request();
		logic action;
		logic [IDX_W-1:0] idx;
		logic [AMT_W-1:0] amount;
		action = ($urandom_range(99) < 6) ? ACT_CLEAR : ACT_ADD;
		idx = ($urandom_range(1)) ? IDX_W'($urandom_range(7)) : IDX_W'($urandom);
		case ($urandom_range(5))
			0: amount = '0;
			1: amount = {AMT_W{1'b1}};
			2: amount = AMT_W'($urandom_range(255));
			default: amount = AMT_W'($urandom);
		endcase
		send_request(action, idx, amount);
	endtask

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		entry_t e;
		req.valid = 1'b0;
		req.action = ACT_ADD;
		req.counter_index = '0;
		req.amount = '0;
		for (int i = 0; i < NUM_COUNTERS; i++) begin
			tot_q[i] = '0; cnt_q[i] = '0; min_q[i] = '0; max_q[i] = '0;
			mean_q[i] = '0; sq_q[i] = '0; ovf_q[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: typed figures for clears and first samples.
		e = '0;
		rows.push_back('{ACT_CLEAR, 6'd0, '0, 1'b1, e});
		e = '0; e.total = 48'hFFFFFF; e.sample_count = 1; e.minimum = 24'hFFFFFF;
		e.maximum = 24'hFFFFFF; e.mean = 40'hFFFFFF0000;
		rows.push_back('{ACT_ADD, 6'd63, 24'hFFFFFF, 1'b1, e});
		rows.push_back('{ACT_ADD, 6'd63, 24'h000000, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd63, 24'hFFFFFF, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd63, 24'h000001, 1'b0, e});
		e = '0; e.sample_count = 1;
		rows.push_back('{ACT_ADD, 6'd0, 24'h000000, 1'b1, e});
		rows.push_back('{ACT_ADD, 6'd0, 24'h000000, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd0, 24'hAAAAAA, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd0, 24'h555555, 1'b0, e});
		e = '0;
		rows.push_back('{ACT_CLEAR, 6'd63, 24'hFFFFFF, 1'b1, e});
		e = '0; e.total = 5; e.sample_count = 1; e.minimum = 5; e.maximum = 5;
		e.mean = 40'h0000050000;
		rows.push_back('{ACT_ADD, 6'd63, 24'd5, 1'b1, e});
		rows.push_back('{ACT_ADD, 6'd63, 24'd7, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd42, 24'd1, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd21, 24'h800000, 1'b0, e});
		rows.push_back('{ACT_ADD, 6'd21, 24'h7FFFFF, 1'b0, e});
		foreach (rows[i]) begin
			row = rows[i];
			send_request(row.action, row.idx, row.amount);
			// Replace the predicted figures with the hand-typed ones on typed rows.
			if (row.typed) begin
				figures_due.pop_back();
				figures_due.push_back(row.want);
			end
		end
		wait_drained();

		// Large deviations: alternate the extremes on one counter so every add after the first
		// moves the mean far and grows the squared sum by a wide product.
		for (int i = 0; i < 40; i++) send_request(ACT_ADD, 6'd9,
			(i % 2) ? 24'hFFFFFF : 24'h000000);

		// Long receiver hold-off with the sender still offering requests.
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 6; i++) random_request();
		join
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 73 : 0;
			recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 19 : 0;
			for (int i = 0; i < 250; i++) random_request();
			// Let everything drain before the next phase.
			wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests, checked %0d responses, %0d with overflow set.",
			accepted, responses, ovf_seen);
		if (mismatches == 0 && figures_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d responses missing", mismatches, figures_due.size());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
`default_nettype wire
